FILE: src/qtss_pkg.sv
// ----------------------------------------------------------------------------
// qtss_pkg
// Shared types and constants of the quoted token span scanner.
// ----------------------------------------------------------------------------
package qtss_pkg;

  localparam int INDEX_WIDTH_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam int CHAR_W   = 8;
  localparam int OP_W     = 2;
  localparam int ACT_W    = 2;
  localparam int CNT_W    = 16;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_DATA_W = 72;

  localparam logic [OP_W-1:0] OP_PUSH      = 2'd0;
  localparam logic [OP_W-1:0] OP_CLR_TOKEN = 2'd1;
  localparam logic [OP_W-1:0] OP_CLR_ALL   = 2'd2;

  localparam logic [ACT_W-1:0] ACT_CONTINUE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DONE     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ILLEGAL  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATORS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTES     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIMS      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NUL_ENDS   = 2'd3;

  localparam logic [CFG_W-1:0] SEPARATORS_RST = 32'h0000_002C;
  localparam logic [CFG_W-1:0] QUOTES_RST     = 32'h0000_2222;
  localparam logic [CFG_W-1:0] TRIMS_RST      = 32'h0000_0920;

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [CHAR_W-1:0] ch;
    logic              is_nul;
    logic              nul_ok;
    logic              is_newline;
    logic              is_sep;
    logic              is_trim;
    logic              qstart;
    logic [CHAR_W-1:0] qclose;
  } cls_t;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [CNT_W-1:0] token_first;
    logic             first_valid;
    logic [CNT_W-1:0] token_last;
    logic             last_valid;
    logic             inside_quote;
    logic [CNT_W-1:0] line_number;
    logic [CNT_W-1:0] column_number;
  } res_t;

endpackage

FILE: src/qtss_front.sv
// ----------------------------------------------------------------------------
// qtss_front
// Configuration registers and character classification of incoming items.
// ----------------------------------------------------------------------------
module qtss_front import qtss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [OP_W-1:0]      op_i,
  input  logic [CHAR_W-1:0]    ch_i,
  output cls_t                 cls_o
);

  logic [CFG_W-1:0] sep_r;
  logic [CFG_W-1:0] quote_r;
  logic [CFG_W-1:0] trim_r;
  logic             nul_ends_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r      <= SEPARATORS_RST;
      quote_r    <= QUOTES_RST;
      trim_r     <= TRIMS_RST;
      nul_ends_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SEPARATORS: sep_r      <= cfg_wdata;
        CFG_QUOTES:     quote_r    <= cfg_wdata;
        CFG_TRIMS:      trim_r     <= cfg_wdata;
        CFG_NUL_ENDS:   nul_ends_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  logic [3:0] sep_hit;
  logic [3:0] trim_hit;
  logic [3:0] q_hit;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sep_hit[i]  = (sep_r[8*i +: 8] != '0) && (sep_r[8*i +: 8] == ch_i);
      trim_hit[i] = (trim_r[8*i +: 8] != '0) && (trim_r[8*i +: 8] == ch_i);
      q_hit[i]    = (quote_r[8*i +: 8] != '0) && (quote_r[8*i +: 8] == ch_i);
    end
  end

  always_comb begin
    cls_o.op         = op_i;
    cls_o.ch         = ch_i;
    cls_o.is_nul     = (ch_i == '0);
    cls_o.nul_ok     = nul_ends_r;
    cls_o.is_newline = (ch_i == NEWLINE_CHAR);
    cls_o.is_sep     = |sep_hit;
    cls_o.is_trim    = |trim_hit;
    // first matching slot decides; only an open slot starts quoting
    cls_o.qstart     = q_hit[0] || (!q_hit[1] && q_hit[2]);
    cls_o.qclose     = q_hit[0] ? quote_r[15:8] : quote_r[31:24];
  end

endmodule

FILE: src/qtss_queue.sv
// ----------------------------------------------------------------------------
// qtss_queue
// Short queue of classified items between front and back.
// ----------------------------------------------------------------------------
module qtss_queue import qtss_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_i,
  input  cls_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cls_t data_o
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_QW-1:0] DEPTH_C = CNT_QW'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0]  LAST_C  = PTR_W'(QUEUE_DEPTH - 1);

  cls_t              mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_QW-1:0] count_r, count_nxt;

  assign full_o  = (count_r == DEPTH_C);
  assign valid_o = (count_r != '0);
  assign data_o  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem[wr_ptr_r] <= data_i;
    end
  end

endmodule

FILE: src/qtss_back.sv
// ----------------------------------------------------------------------------
// qtss_back
// Token span, quote and position state; registered result stage.
// ----------------------------------------------------------------------------
module qtss_back import qtss_pkg::*; #(
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic valid_i,
  input  cls_t cls_i,
  output logic pop_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t res_o
);

  logic [CHAR_W-1:0]      awaited_r, awaited_nxt;
  logic [INDEX_WIDTH-1:0] first_r, first_nxt;
  logic                   first_ok_r, first_ok_nxt;
  logic [INDEX_WIDTH-1:0] last_r, last_nxt;
  logic                   last_ok_r, last_ok_nxt;
  logic [INDEX_WIDTH-1:0] pos_r, pos_nxt;
  logic [CNT_W-1:0]       row_r, row_nxt;
  logic [CNT_W-1:0]       col_r, col_nxt;
  logic [ACT_W-1:0]       action;
  logic                   take;
  logic                   incl;
  logic                   out_valid_r;
  res_t                   res_r;

  logic [INDEX_WIDTH+CNT_W-1:0] first_ext;
  logic [INDEX_WIDTH+CNT_W-1:0] last_ext;

  assign take        = valid_i && (!out_valid_r || out_ready_i);
  assign pop_o       = take;
  assign out_valid_o = out_valid_r;
  assign res_o       = res_r;

  always_comb begin
    awaited_nxt  = awaited_r;
    first_nxt    = first_r;
    first_ok_nxt = first_ok_r;
    last_nxt     = last_r;
    last_ok_nxt  = last_ok_r;
    pos_nxt      = pos_r;
    row_nxt      = row_r;
    col_nxt      = col_r;
    action       = ACT_CONTINUE;
    incl         = 1'b0;
    case (cls_i.op)
      OP_PUSH: begin
        if (cls_i.is_newline) begin
          col_nxt = CNT_W'(1);
          row_nxt = row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
        pos_nxt = pos_r + 1'b1;
        if (cls_i.is_nul) begin
          if ((awaited_r != '0) || !cls_i.nul_ok) begin
            action = ACT_ILLEGAL;
          end else begin
            action = ACT_DONE;
            if (first_ok_r && !last_ok_r) begin
              last_nxt    = pos_r;
              last_ok_nxt = 1'b1;
            end
          end
        end else if (awaited_r != '0) begin
          if (cls_i.ch == awaited_r) begin
            awaited_nxt = '0;
            incl        = 1'b1;
          end
        end else if (cls_i.is_sep) begin
          action = ACT_DONE;
          if (!last_ok_r) begin
            last_nxt    = pos_r;
            last_ok_nxt = 1'b1;
          end
        end else if (cls_i.qstart) begin
          awaited_nxt = cls_i.qclose;
        end else if (!cls_i.is_trim) begin
          incl = 1'b1;
        end
        if (incl) begin
          if (!first_ok_r || (pos_r < first_r)) begin
            first_nxt    = pos_r;
            first_ok_nxt = 1'b1;
          end
          if (!last_ok_r || (pos_r > last_r)) begin
            last_nxt    = pos_r;
            last_ok_nxt = 1'b1;
          end
        end
      end
      OP_CLR_TOKEN, OP_CLR_ALL: begin
        awaited_nxt  = '0;
        first_nxt    = '0;
        first_ok_nxt = 1'b0;
        last_nxt     = '0;
        last_ok_nxt  = 1'b0;
        if (cls_i.op == OP_CLR_ALL) begin
          pos_nxt = '0;
          row_nxt = '0;
          col_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  assign first_ext = {{CNT_W{1'b0}}, first_nxt};
  assign last_ext  = {{CNT_W{1'b0}}, last_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      awaited_r   <= '0;
      first_r     <= '0;
      first_ok_r  <= 1'b0;
      last_r      <= '0;
      last_ok_r   <= 1'b0;
      pos_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        awaited_r  <= awaited_nxt;
        first_r    <= first_nxt;
        first_ok_r <= first_ok_nxt;
        last_r     <= last_nxt;
        last_ok_r  <= last_ok_nxt;
        pos_r      <= pos_nxt;
        row_r      <= row_nxt;
        col_r      <= col_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r.action        <= action;
      res_r.token_first   <= first_ext[CNT_W-1:0];
      res_r.first_valid   <= first_ok_nxt;
      res_r.token_last    <= last_ext[CNT_W-1:0];
      res_r.last_valid    <= last_ok_nxt;
      res_r.inside_quote  <= (awaited_nxt != '0);
      res_r.line_number   <= row_nxt;
      res_r.column_number <= col_nxt;
    end
  end

endmodule

FILE: src/quoted_token_span_scanner_top.sv
// ----------------------------------------------------------------------------
// quoted_token_span_scanner_top
// Character-stream tokenizer reporting quoted token spans and position.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while out_tready is high and returns one
// result per transaction, in order. A transaction goes through the classifier
// into a two-entry queue and then into the result register on out_tdata; the
// update of the token, quote and position registers in the back stage sets
// the rate of one transaction per cycle. Configuration writes take effect on
// the next cycle and are expected only while no transaction is in flight.
module quoted_token_span_scanner_top import qtss_pkg::*; #(
  parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // [7:0] char_in
  input  logic [1:0]            in_tuser,   // [1:0] operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] action, [17:2] token_first, [18] first_valid, [34:19] token_last,
  // [35] last_valid, [36] inside_quote, [52:37] line_number,
  // [68:53] column_number, [71:69] zero
  output logic [OUT_DATA_W-1:0] out_tdata
);

  cls_t cls_in;
  cls_t cls_head;
  res_t res;
  logic q_full;
  logic q_valid;
  logic q_pop;
  logic in_fire;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  qtss_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .op_i      (in_tuser),
    .ch_i      (in_tdata),
    .cls_o     (cls_in)
  );

  qtss_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (in_fire),
    .data_i  (cls_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (cls_head)
  );

  qtss_back #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .valid_i     (q_valid),
    .cls_i       (cls_head),
    .pop_o       (q_pop),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .res_o       (res)
  );

  assign out_tdata = {3'b000,
                      res.column_number,
                      res.line_number,
                      res.inside_quote,
                      res.last_valid,
                      res.token_last,
                      res.first_valid,
                      res.token_first,
                      res.action};

`ifndef SYNTHESIS
  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_done_not_quoting: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res.action == ACT_DONE) |-> !res.inside_quote)
    else $error("token closed while an end quote is awaited");

  a_first_implies_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res.first_valid) |-> res.last_valid)
    else $error("span start valid without span end");

  a_pop_only_when_queued: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("back stage took an item from an empty queue");
`endif

endmodule

FILE: verif/quoted_token_span_scanner_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_token_span_scanner_top_tb
// Self-checking testbench of the quoted token span scanner.
// A short directed table covers every operation, hidden characters and NUL
// while quoting, separators without a token, odd-slot and zero-close quotes,
// and NUL as an error. Random character streams follow under several register
// settings, from all-zero to all-ones slots. Both stream sides stall at
// random. Every report is compared field by field with a table entry or a
// cycle-free model of the scanner kept in the testbench.
// ----------------------------------------------------------------------------
module quoted_token_span_scanner_top_tb;
  import qtss_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
  localparam int              SEG_ITEMS   = 175;
  localparam int              CYCLE_LIMIT = 400_000;

  typedef struct packed {
    logic              is_cfg;
    logic [1:0]        sel;
    logic [CFG_W-1:0]  data;
    logic              typed;
    res_t              want;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // register copies
  logic [CFG_W-1:0] sep_slots   = SEPARATORS_RST;
  logic [CFG_W-1:0] quote_slots = QUOTES_RST;
  logic [CFG_W-1:0] trim_slots  = TRIMS_RST;
  logic             nul_closes  = 1'b1;

  // token and position state
  logic [CHAR_W-1:0]          tk_close = '0;
  logic [CNT_W-1:0]           tk_first = '0;
  logic                       tk_first_ok = 1'b0;
  logic [CNT_W-1:0]           tk_last = '0;
  logic                       tk_last_ok = 1'b0;
  logic [INDEX_WIDTH_DEF-1:0] tk_pos = '0;
  logic [CNT_W-1:0]           tk_row = '0;
  logic [CNT_W-1:0]           tk_col = '0;

  res_t span_reports_due[$];
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   cycle_count = 0;
  int   fail_count = 0;
  int   items_sent = 0;
  int   reg_writes = 0;
  int   reports_seen = 0;
  int   done_seen = 0;
  int   illegal_seen = 0;
  int   quoted_seen = 0;

  plan_row_t plan_rows [25] = '{
    '{1'b0, OP_CLR_ALL,   32'h00, 1'b1, '{ACT_CONTINUE, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0}},
    '{1'b0, OP_PUSH,      32'h61, 1'b1, '{ACT_CONTINUE, 16'd0, 1'b1, 16'd0, 1'b1, 1'b0, 16'd0, 16'd1}},
    '{1'b0, OP_PUSH,      32'h20, 1'b0, '0},
    '{1'b0, OP_PUSH,      32'h62, 1'b0, '0},
    '{1'b0, OP_PUSH,      32'h2C, 1'b0, '0},
    '{1'b0, OP_CLR_TOKEN, 32'h00, 1'b0, '0},
    '{1'b0, OP_PUSH,      32'h2C, 1'b0, '0},
    '{1'b0, OP_UNUSED,    32'hFF, 1'b0, '0},
    '{1'b0, OP_PUSH,      32'h0A, 1'b0, '0},
    '{1'b0, OP_PUSH,      32'h00, 1'b0, '0},
    '{1'b0, OP_CLR_ALL,   32'h00, 1'b1, '{ACT_CONTINUE, 16'd0, 1'b0, 16'd0, 1'b0, 1'b0, 16'd0, 16'd0}},
    '{1'b0, OP_PUSH,      32'h22, 1'b1, '{ACT_CONTINUE, 16'd0, 1'b0, 16'd0, 1'b0, 1'b1, 16'd0, 16'd1}},
    '{1'b0, OP_PUSH,      32'h2C, 1'b1, '{ACT_CONTINUE, 16'd0, 1'b0, 16'd0, 1'b0, 1'b1, 16'd0, 16'd2}},
    '{1'b0, OP_PUSH,      32'h00, 1'b1, '{ACT_ILLEGAL,  16'd0, 1'b0, 16'd0, 1'b0, 1'b1, 16'd0, 16'd3}},
    '{1'b0, OP_PUSH,      32'h22, 1'b1, '{ACT_CONTINUE, 16'd3, 1'b1, 16'd3, 1'b1, 1'b0, 16'd0, 16'd4}},
    '{1'b0, OP_PUSH,      32'hFF, 1'b0, '0},
    '{1'b0, OP_PUSH,      32'h00, 1'b0, '0},
    '{1'b1, CFG_QUOTES,   32'h0027_2200, 1'b0, '0},
    '{1'b0, OP_PUSH,      32'h22, 1'b0, '0},
    '{1'b0, OP_PUSH,      32'h27, 1'b0, '0},
    '{1'b1, CFG_NUL_ENDS, 32'h00, 1'b0, '0},
    '{1'b0, OP_CLR_TOKEN, 32'h00, 1'b0, '0},
    '{1'b0, OP_PUSH,      32'h78, 1'b0, '0},
    '{1'b0, OP_PUSH,      32'h00, 1'b0, '0},
    '{1'b0, OP_PUSH,      32'h09, 1'b0, '0}
  };

  quoted_token_span_scanner_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic bit slot_hit(logic [CFG_W-1:0] slots, logic [CHAR_W-1:0] c);
    for (int k = 0; k < 4; k++) begin
      if (slots[8*k +: 8] != 8'h00 && slots[8*k +: 8] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int quote_slot(logic [CHAR_W-1:0] c);
    for (int k = 0; k < 4; k++) begin
      if (quote_slots[8*k +: 8] != 8'h00 && quote_slots[8*k +: 8] == c) return k;
    end
    return -1;
  endfunction

  function automatic void widen_span(logic [CNT_W-1:0] p);
    if (!tk_first_ok || p < tk_first) begin
      tk_first    = p;
      tk_first_ok = 1'b1;
    end
    if (!tk_last_ok || p > tk_last) begin
      tk_last    = p;
      tk_last_ok = 1'b1;
    end
  endfunction

  function automatic void clear_token();
    tk_close    = '0;
    tk_first    = '0;
    tk_first_ok = 1'b0;
    tk_last     = '0;
    tk_last_ok  = 1'b0;
  endfunction

  // advance the scanner state by one transaction and return its report
  function automatic res_t scan_step(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch);
    res_t                       r;
    logic [ACT_W-1:0]           act;
    logic [INDEX_WIDTH_DEF-1:0] p;
    int                         slot;
    act = ACT_CONTINUE;
    p   = tk_pos;
    case (op)
      OP_PUSH: begin
        if (ch == NEWLINE_CHAR) begin
          tk_col = 16'd1;
          tk_row = tk_row + 16'd1;
        end else begin
          tk_col = tk_col + 16'd1;
        end
        tk_pos = tk_pos + 1'b1;
        if (ch == 8'h00) begin
          if (tk_close != 8'h00 || !nul_closes) begin
            act = ACT_ILLEGAL;
          end else begin
            act = ACT_DONE;
            if (tk_first_ok && !tk_last_ok) begin
              tk_last    = p;
              tk_last_ok = 1'b1;
            end
          end
        end else if (tk_close != 8'h00) begin
          if (ch == tk_close) begin
            tk_close = 8'h00;
            widen_span(p);
          end
        end else if (slot_hit(sep_slots, ch)) begin
          act = ACT_DONE;
          if (!tk_last_ok) begin
            tk_last    = p;
            tk_last_ok = 1'b1;
          end
        end else begin
          slot = quote_slot(ch);
          if (slot >= 0 && slot % 2 == 0) begin
            tk_close = quote_slots[8*(slot+1) +: 8];
          end else if (!slot_hit(trim_slots, ch)) begin
            widen_span(p);
          end
        end
      end
      OP_CLR_TOKEN: begin
        clear_token();
      end
      OP_CLR_ALL: begin
        clear_token();
        tk_pos = '0;
        tk_row = '0;
        tk_col = '0;
      end
      default: begin
      end
    endcase
    r.action        = act;
    r.token_first   = tk_first;
    r.first_valid   = tk_first_ok;
    r.token_last    = tk_last;
    r.last_valid    = tk_last_ok;
    r.inside_quote  = (tk_close != 8'h00);
    r.line_number   = tk_row;
    r.column_number = tk_col;
    return r;
  endfunction

  function automatic res_t unpack_report(logic [OUT_DATA_W-1:0] d);
    res_t r;
    r.action        = d[1:0];
    r.token_first   = d[17:2];
    r.first_valid   = d[18];
    r.token_last    = d[34:19];
    r.last_valid    = d[35];
    r.inside_quote  = d[36];
    r.line_number   = d[52:37];
    r.column_number = d[68:53];
    return r;
  endfunction

  function automatic string show_report(res_t r);
    return $sformatf("act=%0d first=%0d/%0b last=%0d/%0b quote=%0b row=%0d col=%0d",
                     r.action, r.token_first, r.first_valid, r.token_last, r.last_valid,
                     r.inside_quote, r.line_number, r.column_number);
  endfunction

  function automatic string report_diffs(res_t want, res_t got);
    string s;
    s = "";
    if (got.action !== want.action) s = {s, " action"};
    if (got.token_first !== want.token_first) s = {s, " token_first"};
    if (got.first_valid !== want.first_valid) s = {s, " first_valid"};
    if (got.token_last !== want.token_last) s = {s, " token_last"};
    if (got.last_valid !== want.last_valid) s = {s, " last_valid"};
    if (got.inside_quote !== want.inside_quote) s = {s, " inside_quote"};
    if (got.line_number !== want.line_number) s = {s, " line_number"};
    if (got.column_number !== want.column_number) s = {s, " column_number"};
    return s;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin : report_check
    res_t  got;
    res_t  want;
    string diffs;
    if (rst_n && out_tvalid && out_tready) begin
      got = unpack_report(out_tdata);
      reports_seen++;
      if (got.action == ACT_DONE) done_seen++;
      if (got.action == ACT_ILLEGAL) illegal_seen++;
      if (got.inside_quote) quoted_seen++;
      if (span_reports_due.size() == 0) begin
        note_failure($sformatf("report with none pending: %s", show_report(got)));
      end else begin
        want  = span_reports_due.pop_front();
        diffs = report_diffs(want, got);
        if (diffs != "") begin
          note_failure($sformatf("report %0d differs in%s\n  expected %s\n  actual   %s",
                                 reports_seen, diffs, show_report(want), show_report(got)));
        end
      end
    end
  end

  // hold valid across back-to-back transactions; drop it only for a gap
  task automatic push_item(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch, logic typed,
                           res_t typed_report);
    res_t due;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= ch;
    do @(posedge clk); while (!in_tready);
    due = scan_step(op, ch);
    span_reports_due.push_back(typed ? typed_report : due);
    items_sent++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    in_tvalid <= 1'b0;
    while (span_reports_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_SEPARATORS: sep_slots = val;
      CFG_QUOTES:     quote_slots = val;
      CFG_TRIMS:      trim_slots = val;
      CFG_NUL_ENDS:   nul_closes = val[0];
      default: begin
      end
    endcase
  endtask

  function automatic logic [CFG_W-1:0] random_slots();
    logic [CFG_W-1:0] w;
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(3))
        0: w[8*k +: 8] = 8'h00;
        1: w[8*k +: 8] = 8'($urandom_range(255));
        default: w[8*k +: 8] = 8'($urandom_range(8'h21, 8'h7E));
      endcase
    end
    return w;
  endfunction

  // favor bytes the current settings treat specially
  function automatic logic [CHAR_W-1:0] pick_char();
    int roll;
    roll = $urandom_range(99);
    if (roll < 35) return 8'($urandom_range(8'h61, 8'h7A));
    if (roll < 50) return sep_slots[8*$urandom_range(3) +: 8];
    if (roll < 68) return quote_slots[8*$urandom_range(3) +: 8];
    if (roll < 78) return trim_slots[8*$urandom_range(3) +: 8];
    if (roll < 83) return NEWLINE_CHAR;
    if (roll < 88) return 8'h00;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [OP_W-1:0] pick_op();
    int roll;
    roll = $urandom_range(99);
    if (roll < 90) return OP_PUSH;
    if (roll < 94) return OP_CLR_TOKEN;
    if (roll < 97) return OP_CLR_ALL;
    return OP_UNUSED;
  endfunction

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d reports pending", cycle_count,
             span_reports_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 35;
    recv_idle_pct = 87;
    foreach (plan_rows[i]) begin
      if (plan_rows[i].is_cfg) begin
        write_reg(plan_rows[i].sel, plan_rows[i].data);
      end else begin
        push_item(plan_rows[i].sel, plan_rows[i].data[7:0], plan_rows[i].typed,
                  plan_rows[i].want);
      end
    end

    for (int seg = 0; seg < 6; seg++) begin
      case (seg / 2)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 87;
        end
        1: begin
          send_idle_pct = 87;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (seg)
        0: begin
          write_reg(CFG_SEPARATORS, SEPARATORS_RST);
          write_reg(CFG_QUOTES, QUOTES_RST);
          write_reg(CFG_TRIMS, TRIMS_RST);
          write_reg(CFG_NUL_ENDS, 32'd1);
        end
        1: begin
          write_reg(CFG_SEPARATORS, '0);
          write_reg(CFG_QUOTES, '0);
          write_reg(CFG_TRIMS, '0);
          write_reg(CFG_NUL_ENDS, '0);
        end
        2: begin
          write_reg(CFG_SEPARATORS, '1);
          write_reg(CFG_QUOTES, '1);
          write_reg(CFG_TRIMS, '1);
          write_reg(CFG_NUL_ENDS, '1);
        end
        4: begin
          write_reg(CFG_SEPARATORS, 32'h7C0A_3B2C);
          write_reg(CFG_QUOTES, 32'h5D5B_2928);
          write_reg(CFG_TRIMS, 32'h000D_0920);
          write_reg(CFG_NUL_ENDS, 32'd1);
        end
        default: begin
          write_reg(CFG_SEPARATORS, random_slots());
          write_reg(CFG_QUOTES, random_slots());
          write_reg(CFG_TRIMS, random_slots());
          write_reg(CFG_NUL_ENDS, 32'($urandom_range(1)));
        end
      endcase
      repeat (SEG_ITEMS) push_item(pick_op(), pick_char(), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (span_reports_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Scanned %0d transactions across %0d register writes, %0d reports checked",
             items_sent, reg_writes, reports_seen);
    $display("  %0d done, %0d illegal, %0d while quoting, %0d mismatches",
             done_seen, illegal_seen, quoted_seen, fail_count);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
